>>> design/qltu_pkg.sv
// Shared types and constants of the Q-learning table update unit.
package qltu_pkg;

   localparam int STATE_W    = 4;
   localparam int REWARD_W   = 16;
   localparam int VALUE_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int RAND_W     = 16;
   localparam int DIV_CNT_W  = 4;
   localparam int MASK_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [FRAC_W-1:0]  LEARN_RATE_RST = 16'd32768;
   localparam logic [FRAC_W-1:0]  DISCOUNT_RST   = 16'd52429;
   localparam logic [STATE_W-1:0] GOAL_RST       = 4'd15;
   localparam logic [MASK_W-1:0]  OBSTACLE_RST   = 16'd0;

   localparam logic signed [REWARD_W-1:0] NO_MOVE_REWARD = -16'sd1;
   localparam logic signed [VALUE_W-1:0]  Q_FLOOR        = 32'sd1;
   localparam logic [DIV_CNT_W-1:0]       DIV_LAST       = 4'd15;

   typedef enum logic [2:0] {
      FN_WR_REWARD = 3'd0,
      FN_WR_Q      = 3'd1,
      FN_LEARN     = 3'd2,
      FN_GREEDY    = 3'd3,
      FN_RD_Q      = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OBSTACLE = 2'd1,
      ST_NO_MOVE  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARN_RATE = 2'd0,
      CSR_DISCOUNT   = 2'd1,
      CSR_GOAL       = 2'd2,
      CSR_OBSTACLE   = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      RA_CELL,
      RA_SCAN,
      RA_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      SM_COUNT,
      SM_NTH,
      SM_MAX
   } scan_mode_type;

   typedef enum logic [2:0] {
      RS_ZERO,
      RS_ECHO,
      RS_READ,
      RS_GOAL,
      RS_OBST,
      RS_NOMOVE,
      RS_GREEDY,
      RS_LEARN
   } res_sel_type;

   typedef enum logic [4:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_DECODE,
      CS_RDQ,
      CS_SCAN1,
      CS_DRAIN1,
      CS_CHECK,
      CS_DIV,
      CS_NINIT,
      CS_SCAN2,
      CS_DRAIN2,
      CS_SELN,
      CS_RDN,
      CS_CAPN,
      CS_SCAN3,
      CS_DRAIN3,
      CS_MUL1,
      CS_DIFF,
      CS_MUL2,
      CS_UPDATE
   } ctrl_state_type;

   typedef struct packed {
      logic          cap;
      logic          clr_step;
      logic          rew_we;
      logic          val_wq;
      logic          val_upd;
      rd_sel_type    rd_sel;
      logic          row_n;
      logic          scan_init;
      logic          scan;
      scan_mode_type mode;
      logic          div_init;
      logic          div_step;
      logic          sel_n;
      logic          cap_n;
      logic          res_load;
      res_sel_type   res_sel;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     from_ok;
      logic     is_goal;
      logic     is_obst;
      logic     cnt_zero;
      logic     scan_last;
      logic     div_last;
      logic     clr_last;
   } stat_type;

endpackage

>>> design/q_learning_table_update_unit.sv
// Top level of the Q-learning table update unit: controller plus datapath.
//
//   channel   direction  handshake               payload
//   request   in         start & !busy           req_func .. req_rand_value
//   response  out        rsp_valid, one cycle    rsp_next_state .. rsp_status
//   csr       in         csr_valid & csr_ready   csr_index, csr_wdata
//
// The time a greedy or learn step takes is set by the row scans through the
// single-read table port and the 16-step remainder loop. After reset the Q
// table is cleared one entry a cycle with busy high; csr writes are taken
// throughout. The result strobe cannot be stalled, and busy stays high from
// accept until the result cycle.
module q_learning_table_update_unit import qltu_pkg::*; #(
   parameter int NUM_STATES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_func,
   input  logic [STATE_W-1:0]           req_from_state,
   input  logic [STATE_W-1:0]           req_to_state,
   input  logic signed [REWARD_W-1:0]   req_reward_in,
   input  logic signed [VALUE_W-1:0]    req_q_in,
   input  logic [RAND_W-1:0]            req_rand_value,
   output logic                         rsp_valid,
   output logic [STATE_W-1:0]           rsp_next_state,
   output logic signed [VALUE_W-1:0]    rsp_q_out,
   output logic                         rsp_episode_done,
   output logic [1:0]                   rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // registers are plain flops: always take the write
   assign csr_ready = 1'b1;

   qltu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   qltu_datapath #(
      .NUM_STATES (NUM_STATES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_from_state   (req_from_state),
      .req_to_state     (req_to_state),
      .req_reward_in    (req_reward_in),
      .req_q_in         (req_q_in),
      .req_rand_value   (req_rand_value),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_next_state   (rsp_next_state),
      .rsp_q_out        (rsp_q_out),
      .rsp_episode_done (rsp_episode_done),
      .rsp_status       (rsp_status)
   );

   // an accepted request keeps the unit busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // one result per request: never two strobes in a row
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // a result only follows issued work, so busy was high the cycle before
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   // obstacle status always ends the episode
   a_obstacle_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OBSTACLE) |-> rsp_episode_done)
      else $error("obstacle status without episode_done");

endmodule

>>> design/qltu_ctrl.sv
// Sequencing state machine of the Q-learning table update unit.
module qltu_ctrl import qltu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_CLEAR: begin
            if (stat.clr_last) state_in = CS_IDLE;
         end
         CS_IDLE: begin
            if (start) state_in = CS_DECODE;
         end
         CS_DECODE: begin
            case (stat.func)
               FN_RD_Q: state_in = CS_RDQ;
               FN_LEARN, FN_GREEDY: begin
                  if (stat.is_goal || stat.is_obst || !stat.from_ok) state_in = CS_IDLE;
                  else state_in = CS_SCAN1;
               end
               default: state_in = CS_IDLE;
            endcase
         end
         CS_RDQ:    state_in = CS_IDLE;
         CS_SCAN1: begin
            if (stat.scan_last) state_in = CS_DRAIN1;
         end
         CS_DRAIN1: state_in = CS_CHECK;
         CS_CHECK: begin
            if (stat.cnt_zero) state_in = CS_IDLE;
            else state_in = CS_DIV;
         end
         CS_DIV: begin
            if (stat.div_last) state_in = CS_NINIT;
         end
         CS_NINIT:  state_in = CS_SCAN2;
         CS_SCAN2: begin
            if (stat.scan_last) state_in = CS_DRAIN2;
         end
         CS_DRAIN2: state_in = CS_SELN;
         CS_SELN:   state_in = CS_RDN;
         CS_RDN:    state_in = CS_CAPN;
         CS_CAPN: begin
            if (stat.func == FN_GREEDY) state_in = CS_IDLE;
            else state_in = CS_SCAN3;
         end
         CS_SCAN3: begin
            if (stat.scan_last) state_in = CS_DRAIN3;
         end
         CS_DRAIN3: state_in = CS_MUL1;
         CS_MUL1:   state_in = CS_DIFF;
         CS_DIFF:   state_in = CS_MUL2;
         CS_MUL2:   state_in = CS_UPDATE;
         CS_UPDATE: state_in = CS_IDLE;
         default:   state_in = CS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = (state_ff != CS_IDLE);
      case (state_ff)
         CS_CLEAR: cmd.clr_step = 1'b1;
         CS_IDLE:  cmd.cap = start;
         CS_DECODE: begin
            case (stat.func)
               FN_WR_REWARD: begin
                  cmd.rew_we   = 1'b1;
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RS_ZERO;
               end
               FN_WR_Q: begin
                  cmd.val_wq   = 1'b1;
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RS_ECHO;
               end
               FN_RD_Q: cmd.rd_sel = RA_CELL;
               FN_LEARN, FN_GREEDY: begin
                  if (stat.is_goal) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = RS_GOAL;
                  end else if (stat.is_obst) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = RS_OBST;
                  end else if (!stat.from_ok) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = RS_NOMOVE;
                  end else begin
                     cmd.scan_init = 1'b1;
                     cmd.mode      = SM_COUNT;
                  end
               end
               default: begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RS_ZERO;
               end
            endcase
         end
         CS_RDQ: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RS_READ;
         end
         CS_SCAN1: begin
            cmd.scan   = 1'b1;
            cmd.mode   = SM_COUNT;
            cmd.rd_sel = RA_SCAN;
         end
         CS_CHECK: begin
            if (stat.cnt_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RS_NOMOVE;
            end else begin
               cmd.div_init = 1'b1;
            end
         end
         CS_DIV: cmd.div_step = 1'b1;
         CS_NINIT: begin
            cmd.scan_init = 1'b1;
            cmd.mode      = SM_NTH;
         end
         CS_SCAN2: begin
            cmd.scan   = 1'b1;
            cmd.mode   = SM_NTH;
            cmd.rd_sel = RA_SCAN;
         end
         CS_SELN: cmd.sel_n = 1'b1;
         CS_RDN:  cmd.rd_sel = RA_NEXT;
         CS_CAPN: begin
            cmd.cap_n = 1'b1;
            if (stat.func == FN_GREEDY) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RS_GREEDY;
            end else begin
               cmd.scan_init = 1'b1;
               cmd.mode      = SM_MAX;
               cmd.row_n     = 1'b1;
            end
         end
         CS_SCAN3: begin
            cmd.scan   = 1'b1;
            cmd.mode   = SM_MAX;
            cmd.row_n  = 1'b1;
            cmd.rd_sel = RA_SCAN;
         end
         CS_UPDATE: begin
            cmd.val_upd  = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RS_LEARN;
         end
         default: cmd = '0;
      endcase
   end

endmodule

>>> design/qltu_datapath.sv
// Tables, scan accumulators, divider, update arithmetic and result registers.
module qltu_datapath import qltu_pkg::*; #(
   parameter int NUM_STATES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output stat_type                     stat,
   input  logic [2:0]                   req_func,
   input  logic [STATE_W-1:0]           req_from_state,
   input  logic [STATE_W-1:0]           req_to_state,
   input  logic signed [REWARD_W-1:0]   req_reward_in,
   input  logic signed [VALUE_W-1:0]    req_q_in,
   input  logic [RAND_W-1:0]            req_rand_value,
   input  logic                         csr_valid,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   output logic                         rsp_valid,
   output logic [STATE_W-1:0]           rsp_next_state,
   output logic signed [VALUE_W-1:0]    rsp_q_out,
   output logic                         rsp_episode_done,
   output logic [1:0]                   rsp_status
);

   localparam int DEPTH  = NUM_STATES * NUM_STATES;
   localparam int COL_W  = $clog2(NUM_STATES);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(NUM_STATES + 1);
   localparam int SW     = (COL_W > STATE_W) ? COL_W : STATE_W;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [SW-1:0] row,
                                                   input logic [SW-1:0] col);
      cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(NUM_STATES) + ADDR_W'(col));
   endfunction

   // configuration
   logic [FRAC_W-1:0]  lrate_ff, lrate_in, disc_ff, disc_in;
   logic [STATE_W-1:0] goal_ff, goal_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;

   // captured request
   func_type                    func_ff, func_in;
   logic [STATE_W-1:0]          from_ff, from_in, to_ff, to_in;
   logic signed [REWARD_W-1:0]  rew_ff, rew_in;
   logic signed [VALUE_W-1:0]   qin_ff, qin_in;
   logic [RAND_W-1:0]           rnd_ff, rnd_in;

   // tables
   logic signed [REWARD_W-1:0] rew_mem [DEPTH];
   logic signed [VALUE_W-1:0]  val_mem [DEPTH];
   logic signed [REWARD_W-1:0] rew_rd_ff;
   logic signed [VALUE_W-1:0]  val_rd_ff;
   logic [ADDR_W-1:0]          rd_addr, rew_wa, val_wa;
   logic                       rew_we, val_we;
   logic signed [VALUE_W-1:0]  val_wd;
   logic [ADDR_W-1:0]          clr_ff, clr_in;

   // scan
   logic [COL_W-1:0]          idx_ff, idx_in, idx_d_ff;
   logic                      scan_d_ff;
   scan_mode_type             mode_d_ff;
   logic [CNT_W-1:0]          cnt_ff, cnt_in, k_ff, k_in;
   logic signed [VALUE_W-1:0] best_ff, best_in, mx_ff, mx_in;
   logic [COL_W-1:0]          bidx_ff, bidx_in, nth_ff, nth_in, n_ff, n_in;
   logic                      bvalid_ff, bvalid_in, found_ff, found_in;
   logic                      legal;

   // divider
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W:0]       rem_sh;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // update arithmetic
   logic signed [VALUE_W-1:0]  cur_ff, cur_in;
   logic signed [REWARD_W-1:0] r_ff, r_in;
   logic signed [48:0]         p1_ff, p1_in;
   logic signed [33:0]         d_ff, d_in;
   logic signed [50:0]         p2_ff, p2_in;
   logic signed [32:0]         disc_term;
   logic signed [34:0]         step_term;
   logic signed [35:0]         nv_wide;
   logic signed [VALUE_W-1:0]  nv_sat;

   // result
   logic                      rsp_valid_ff, rsp_valid_in, done_ff, done_in;
   logic [STATE_W-1:0]        next_ff, next_in;
   logic signed [VALUE_W-1:0] q_ff, q_in;
   status_type                st_ff, st_in;

   logic [SW-1:0] from_sw, to_sw, n_sw, idx_sw;
   logic          from_ok, cell_ok, n_done;

   assign from_sw = SW'(from_ff);
   assign to_sw   = SW'(to_ff);
   assign n_sw    = SW'(n_ff);
   assign idx_sw  = SW'(idx_ff);
   assign from_ok = int'(from_ff) < NUM_STATES;
   assign cell_ok = from_ok && (int'(to_ff) < NUM_STATES);
   assign n_done  = (n_sw == SW'(goal_ff)) ||
                    ((int'(n_ff) < MASK_W) && mask_ff[n_sw[STATE_W-1:0]]);
   assign legal   = (rew_rd_ff != NO_MOVE_REWARD);

   assign stat.func      = func_ff;
   assign stat.from_ok   = from_ok;
   assign stat.is_goal   = from_ok && (from_ff == goal_ff);
   assign stat.is_obst   = from_ok && mask_ff[from_ff];
   assign stat.cnt_zero  = (cnt_ff == '0);
   assign stat.scan_last = (idx_ff == COL_W'(NUM_STATES - 1));
   assign stat.div_last  = (div_cnt_ff == DIV_LAST);
   assign stat.clr_last  = (clr_ff == ADDR_W'(DEPTH - 1));

   // table addressing
   always_comb begin
      case (cmd.rd_sel)
         RA_CELL: rd_addr = cell_addr(from_sw, to_sw);
         RA_NEXT: rd_addr = cell_addr(from_sw, n_sw);
         default: rd_addr = cell_addr(cmd.row_n ? n_sw : from_sw, idx_sw);
      endcase
      rew_we = cmd.rew_we && cell_ok;
      rew_wa = cell_addr(from_sw, to_sw);
      val_we = cmd.clr_step || cmd.val_upd || (cmd.val_wq && cell_ok);
      if (cmd.clr_step) begin
         val_wa = clr_ff;
         val_wd = '0;
      end else if (cmd.val_upd) begin
         val_wa = cell_addr(from_sw, n_sw);
         val_wd = nv_sat;
      end else begin
         val_wa = cell_addr(from_sw, to_sw);
         val_wd = qin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rew_we) rew_mem[rew_wa] <= rew_ff;
      if (val_we) val_mem[val_wa] <= val_wd;
      rew_rd_ff <= rew_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
   end

   // update arithmetic: floor shifts are the upper product bits
   always_comb begin
      disc_term = p1_ff[48:16];
      step_term = p2_ff[50:16];
      p1_in     = $signed({1'b0, disc_ff}) * mx_ff;
      d_in      = $signed({{2{r_ff[15]}}, r_ff, 16'h0000})
                  + $signed({disc_term[32], disc_term})
                  - $signed({{2{cur_ff[31]}}, cur_ff});
      p2_in     = $signed({1'b0, lrate_ff}) * d_ff;
      nv_wide   = $signed({{4{cur_ff[31]}}, cur_ff}) + $signed({step_term[34], step_term});
      if (nv_wide[35:31] == 5'b00000 || nv_wide[35:31] == 5'b11111) begin
         nv_sat = nv_wide[31:0];
      end else if (nv_wide[35]) begin
         nv_sat = 32'sh8000_0000;
      end else begin
         nv_sat = 32'sh7FFF_FFFF;
      end
   end

   // next values of control and accumulators
   always_comb begin
      lrate_in = lrate_ff;
      disc_in  = disc_ff;
      goal_in  = goal_ff;
      mask_in  = mask_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_LEARN_RATE: lrate_in = csr_wdata;
            CSR_DISCOUNT:   disc_in  = csr_wdata;
            CSR_GOAL:       goal_in  = csr_wdata[STATE_W-1:0];
            CSR_OBSTACLE:   mask_in  = csr_wdata;
            default:        lrate_in = lrate_ff;
         endcase
      end

      func_in = func_ff;
      from_in = from_ff;
      to_in   = to_ff;
      rew_in  = rew_ff;
      qin_in  = qin_ff;
      rnd_in  = rnd_ff;
      if (cmd.cap) begin
         func_in = func_type'(req_func);
         from_in = req_from_state;
         to_in   = req_to_state;
         rew_in  = req_reward_in;
         qin_in  = req_q_in;
         rnd_in  = req_rand_value;
      end else if (cmd.div_step) begin
         rnd_in = {rnd_ff[RAND_W-2:0], 1'b0};
      end

      clr_in = cmd.clr_step ? clr_ff + 1'b1 : clr_ff;

      idx_in = cmd.scan_init ? '0 : (cmd.scan ? idx_ff + 1'b1 : idx_ff);

      cnt_in    = cnt_ff;
      best_in   = best_ff;
      bidx_in   = bidx_ff;
      bvalid_in = bvalid_ff;
      k_in      = k_ff;
      found_in  = found_ff;
      nth_in    = nth_ff;
      mx_in     = mx_ff;
      if (cmd.scan_init) begin
         case (cmd.mode)
            SM_COUNT: begin
               cnt_in    = '0;
               best_in   = Q_FLOOR;
               bvalid_in = 1'b0;
            end
            SM_NTH: begin
               k_in     = rem_ff;
               found_in = 1'b0;
            end
            default: mx_in = Q_FLOOR;
         endcase
      end else if (scan_d_ff && legal) begin
         case (mode_d_ff)
            SM_COUNT: begin
               cnt_in = cnt_ff + 1'b1;
               if (val_rd_ff > best_ff) begin
                  best_in   = val_rd_ff;
                  bidx_in   = idx_d_ff;
                  bvalid_in = 1'b1;
               end
            end
            SM_NTH: begin
               if (!found_ff) begin
                  if (k_ff == '0) begin
                     nth_in   = idx_d_ff;
                     found_in = 1'b1;
                  end else begin
                     k_in = k_ff - 1'b1;
                  end
               end
            end
            default: begin
               if (val_rd_ff > mx_ff) mx_in = val_rd_ff;
            end
         endcase
      end

      // restoring remainder, one bit of the random value per step
      rem_sh     = {rem_ff, rnd_ff[RAND_W-1]};
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_init) begin
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff + 1'b1;
         if (rem_sh >= {1'b0, cnt_ff}) rem_in = CNT_W'(rem_sh - {1'b0, cnt_ff});
         else rem_in = CNT_W'(rem_sh);
      end

      n_in = n_ff;
      if (cmd.sel_n) n_in = (func_ff == FN_GREEDY && bvalid_ff) ? bidx_ff : nth_ff;

      cur_in = cmd.cap_n ? val_rd_ff : cur_ff;
      r_in   = cmd.cap_n ? rew_rd_ff : r_ff;

      rsp_valid_in = cmd.res_load;
      next_in      = next_ff;
      q_in         = q_ff;
      done_in      = done_ff;
      st_in        = st_ff;
      if (cmd.res_load) begin
         next_in = '0;
         q_in    = '0;
         done_in = 1'b0;
         st_in   = ST_OK;
         case (cmd.res_sel)
            RS_ECHO: q_in = qin_ff;
            RS_READ: q_in = cell_ok ? val_rd_ff : '0;
            RS_GOAL: begin
               next_in = from_ff;
               done_in = 1'b1;
            end
            RS_OBST: begin
               next_in = from_ff;
               done_in = 1'b1;
               st_in   = ST_OBSTACLE;
            end
            RS_NOMOVE: begin
               next_in = from_ff;
               st_in   = ST_NO_MOVE;
            end
            RS_GREEDY: begin
               next_in = STATE_W'(n_ff);
               q_in    = val_rd_ff;
               done_in = n_done;
            end
            RS_LEARN: begin
               next_in = STATE_W'(n_ff);
               q_in    = nv_sat;
               done_in = n_done;
            end
            default: q_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lrate_ff     <= LEARN_RATE_RST;
         disc_ff      <= DISCOUNT_RST;
         goal_ff      <= GOAL_RST;
         mask_ff      <= OBSTACLE_RST;
         clr_ff       <= '0;
         scan_d_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lrate_ff     <= lrate_in;
         disc_ff      <= disc_in;
         goal_ff      <= goal_in;
         mask_ff      <= mask_in;
         clr_ff       <= clr_in;
         scan_d_ff    <= cmd.scan;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff    <= func_in;
      from_ff    <= from_in;
      to_ff      <= to_in;
      rew_ff     <= rew_in;
      qin_ff     <= qin_in;
      rnd_ff     <= rnd_in;
      idx_ff     <= idx_in;
      idx_d_ff   <= idx_ff;
      mode_d_ff  <= cmd.mode;
      cnt_ff     <= cnt_in;
      best_ff    <= best_in;
      bidx_ff    <= bidx_in;
      bvalid_ff  <= bvalid_in;
      k_ff       <= k_in;
      found_ff   <= found_in;
      nth_ff     <= nth_in;
      mx_ff      <= mx_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      n_ff       <= n_in;
      cur_ff     <= cur_in;
      r_ff       <= r_in;
      p1_ff      <= p1_in;
      d_ff       <= d_in;
      p2_ff      <= p2_in;
      next_ff    <= next_in;
      q_ff       <= q_in;
      done_ff    <= done_in;
      st_ff      <= st_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_state   = next_ff;
   assign rsp_q_out        = q_ff;
   assign rsp_episode_done = done_ff;
   assign rsp_status       = st_ff;

endmodule
